>>> rtl/pidl_pkg.sv
// ----------------------------------------------------------------------------
// pidl_pkg: shared types and constants for the positional insert/delete list
// Command, status and cell operation codes, and the default list size.
// ----------------------------------------------------------------------------
`default_nettype none

package pidl_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int DATA_W       = 32;
   localparam int CMD_W        = 2;
   localparam int INDEX_W      = 6;
   localparam int STATUS_W     = 2;
   localparam int COUNT_OUT_W  = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_READ   = 2'd1,
      CMD_INSERT = 2'd2,
      CMD_DELETE = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // what every cell of the row does on a clock edge
   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_WRITE      = 2'd1,
      CELL_SHIFT_UP   = 2'd2,
      CELL_SHIFT_DOWN = 2'd3
   } cell_op_type;

endpackage

`default_nettype wire

>>> rtl/pidl_cell.sv
// ----------------------------------------------------------------------------
// pidl_cell: one element slot of the list
// Holds one element; writes the broadcast value or takes a neighbor's element
// depending on its own position against the broadcast bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module pidl_cell #(
   parameter int CW  = 7,
   parameter int POS = 0
) (
   input  wire                                    clock,
   input  pidl_pkg::cell_op_type                  op,
   input  wire        [CW-1:0]                    pos,
   input  wire        [CW-1:0]                    lim,
   input  wire        [CW-1:0]                    rd_pos,
   input  wire signed [pidl_pkg::DATA_W-1:0]      value,
   input  wire signed [pidl_pkg::DATA_W-1:0]      left_data,
   input  wire signed [pidl_pkg::DATA_W-1:0]      right_data,
   output logic signed [pidl_pkg::DATA_W-1:0]     data_out,
   output logic signed [pidl_pkg::DATA_W-1:0]     sel_data
);

   localparam logic [CW-1:0] POS_V  = CW'(POS);
   localparam logic [CW-1:0] POS_NX = CW'(POS + 1);

   logic signed [pidl_pkg::DATA_W-1:0] elem_ff;
   logic signed [pidl_pkg::DATA_W-1:0] elem_in;

   always_comb begin
      elem_in = elem_ff;
      case (op)
         pidl_pkg::CELL_WRITE: begin
            if (POS_V == pos) elem_in = value;
         end
         pidl_pkg::CELL_SHIFT_UP: begin
            if (POS_V == pos) begin
               elem_in = value;
            end else if (POS_V > pos && POS_V <= lim) begin
               elem_in = left_data;
            end
         end
         pidl_pkg::CELL_SHIFT_DOWN: begin
            if (POS_V >= pos && POS_NX < lim) elem_in = right_data;
         end
         default: elem_in = elem_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
   end

   assign data_out = elem_ff;
   // only the addressed cell puts its element on the read-out or-tree
   assign sel_data = (POS_V == rd_pos) ? elem_ff : '0;

endmodule

`default_nettype wire

>>> rtl/positional_insert_delete_list.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_list: packed list with insert/delete at an index
// A row of element cells plus a count register; one command per cycle.
// ----------------------------------------------------------------------------
// usage:
//   - command channel: a transaction is taken on a rising edge with start high
//     and busy low; busy is always low, so a command can be issued every cycle
//   - commands: load (append, start_req empties first), read at index,
//     insert at index (index equal to count appends), delete at index
//   - result channel: rsp_valid pulses for one cycle, in the cycle after
//     the command edge, with status, data (read or deleted element, else zero)
//     and the element count after the command
//   - throughput 1 transaction per cycle: all cells that shift move their
//     elements to a neighbor on the same edge, so the whole list shifts at
//     once; the read port is one or-tree over cells
//   - bad index gives status 1, full list status 2; the list is unchanged then
//   - reset clears the count and the result strobe; cell contents are not
//     cleared, unused slots are never read back
//   - the receiver cannot stall; results must be taken on the strobe cycle
// ----------------------------------------------------------------------------
`default_nettype none

module positional_insert_delete_list #(
   parameter int CAPACITY = pidl_pkg::CAPACITY_DEF
) (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         start,
   output logic                                        busy,
   input  wire        [pidl_pkg::CMD_W-1:0]            req_command,
   input  wire signed [pidl_pkg::DATA_W-1:0]           req_value,
   input  wire        [pidl_pkg::INDEX_W-1:0]          req_index,
   input  wire                                         req_start_req,
   output logic                                        rsp_valid,
   output logic       [pidl_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [pidl_pkg::DATA_W-1:0]          rsp_data,
   output logic       [pidl_pkg::COUNT_OUT_W-1:0]      rsp_count
);

   // count register width, and a compare width wide enough for index and count
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CW    = (CNT_W > pidl_pkg::COUNT_OUT_W) ? CNT_W : pidl_pkg::COUNT_OUT_W;
   localparam logic [CW-1:0] CAP_V = CW'(CAPACITY);

   // control state
   logic [CNT_W-1:0]                   count_ff;
   logic [CNT_W-1:0]                   count_in;
   logic                               rsp_valid_ff;

   // result payload
   pidl_pkg::status_type               rsp_status_ff;
   pidl_pkg::status_type               rsp_status_in;
   logic signed [pidl_pkg::DATA_W-1:0] rsp_data_ff;
   logic signed [pidl_pkg::DATA_W-1:0] rsp_data_in;
   logic [pidl_pkg::COUNT_OUT_W-1:0]   rsp_count_ff;

   // broadcast to the cell row
   pidl_pkg::cell_op_type              cell_op;
   logic [CW-1:0]                      cell_pos;
   logic [CW-1:0]                      cell_lim;

   logic                               accept;
   pidl_pkg::cmd_type                  cmd;
   logic [CW-1:0]                      idx_ext;
   logic [CW-1:0]                      cnt_ext;
   logic [CW-1:0]                      load_base;
   logic [CW-1:0]                      count_next;
   logic signed [pidl_pkg::DATA_W-1:0] rd_data;

   logic signed [pidl_pkg::DATA_W-1:0] cell_q     [CAPACITY];
   logic signed [pidl_pkg::DATA_W-1:0] cell_sel   [CAPACITY];
   logic signed [pidl_pkg::DATA_W-1:0] cell_left  [CAPACITY];
   logic signed [pidl_pkg::DATA_W-1:0] cell_right [CAPACITY];

   // busy is tied low, so the block never refuses a transaction
   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign cmd    = pidl_pkg::cmd_type'(req_command);

   assign idx_ext   = CW'(req_index);
   assign cnt_ext   = CW'(count_ff);
   // start_req restarts the list, so the append lands at slot zero
   assign load_base = req_start_req ? '0 : cnt_ext;

   // read-out: only the cell at the index drives nonzero data
   always_comb begin
      rd_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_data = rd_data | cell_sel[i];
      end
   end

   // command decode: cell row operation, status, data and new count
   always_comb begin
      cell_op       = pidl_pkg::CELL_HOLD;
      cell_pos      = idx_ext;
      cell_lim      = cnt_ext;
      rsp_status_in = pidl_pkg::STAT_OK;
      rsp_data_in   = '0;
      count_next    = cnt_ext;
      case (cmd)
         pidl_pkg::CMD_LOAD: begin
            if (load_base >= CAP_V) begin
               rsp_status_in = pidl_pkg::STAT_FULL;
            end else begin
               cell_op    = pidl_pkg::CELL_WRITE;
               cell_pos   = load_base;
               count_next = load_base + CW'(1);
            end
         end
         pidl_pkg::CMD_READ: begin
            if (idx_ext < cnt_ext) begin
               rsp_data_in = rd_data;
            end else begin
               rsp_status_in = pidl_pkg::STAT_RANGE;
            end
         end
         pidl_pkg::CMD_INSERT: begin
            // index check goes first, so a bad index on a full list is a range error
            if (idx_ext > cnt_ext) begin
               rsp_status_in = pidl_pkg::STAT_RANGE;
            end else if (cnt_ext >= CAP_V) begin
               rsp_status_in = pidl_pkg::STAT_FULL;
            end else begin
               cell_op    = pidl_pkg::CELL_SHIFT_UP;
               count_next = cnt_ext + CW'(1);
            end
         end
         pidl_pkg::CMD_DELETE: begin
            if (idx_ext < cnt_ext) begin
               rsp_data_in = rd_data;
               cell_op     = pidl_pkg::CELL_SHIFT_DOWN;
               count_next  = cnt_ext - CW'(1);
            end else begin
               rsp_status_in = pidl_pkg::STAT_RANGE;
            end
         end
         default: begin
            cell_op = pidl_pkg::CELL_HOLD;
         end
      endcase
      // nothing moves without a transaction
      if (!accept) begin
         cell_op    = pidl_pkg::CELL_HOLD;
         count_next = cnt_ext;
      end
   end

   assign count_in = count_next[CNT_W-1:0];

   // the cell row; end cells see zero from the missing neighbor
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign cell_left[i] = '0;
      end else begin : g_left
         assign cell_left[i] = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign cell_right[i] = '0;
      end else begin : g_right
         assign cell_right[i] = cell_q[i+1];
      end

      pidl_cell #(
         .CW  (CW),
         .POS (i)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op),
         .pos        (cell_pos),
         .lim        (cell_lim),
         .rd_pos     (idx_ext),
         .value      (req_value),
         .left_data  (cell_left[i]),
         .right_data (cell_right[i]),
         .data_out   (cell_q[i]),
         .sel_data   (cell_sel[i])
      );
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   // result payload, loaded on each transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_count_ff  <= count_next[pidl_pkg::COUNT_OUT_W-1:0];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_count  = rsp_count_ff;

   // every transaction yields its result on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("result strobe missing after a transaction");

   // the count never passes the list size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(count_ff) <= CAP_V)
      else $error("element count above capacity");

   // an error result leaves the count where it was
   a_err_no_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != pidl_pkg::STAT_OK) |-> (count_ff == $past(count_ff)))
      else $error("count changed on a failed command");

endmodule

`default_nettype wire

>>> verif/tb_positional_insert_delete_list.sv
// ----------------------------------------------------------------------------
// tb_positional_insert_delete_list: self-checking bench for the packed list
// Runs a directed opening (empty list, extreme values, full list, bad index),
// then random episodes that grow, shrink or churn the list. Every transaction
// is predicted at the command edge and checked field by field on rsp_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_positional_insert_delete_list;

   localparam int LIST_CAP    = pidl_pkg::CAPACITY_DEF;
   localparam int RAND_ITEMS  = 463;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 8;
   localparam int ROW_COUNT   = 25;

   // one expected response
   typedef struct {
      pidl_pkg::status_type                   status;
      logic signed [pidl_pkg::DATA_W-1:0]     data;
      logic [pidl_pkg::COUNT_OUT_W-1:0]       count;
   } list_result_type;

   // one row of the directed opening; reps above one repeats it with random values after the first
   typedef struct {
      pidl_pkg::cmd_type                      cmd;
      logic signed [pidl_pkg::DATA_W-1:0]     value;
      logic [pidl_pkg::INDEX_W-1:0]           index;
      logic                                   start_req;
      int                                     reps;
      bit                                     typed;
      pidl_pkg::status_type                   status;
      logic signed [pidl_pkg::DATA_W-1:0]     data;
      logic [pidl_pkg::COUNT_OUT_W-1:0]       count;
   } opening_row_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic [pidl_pkg::CMD_W-1:0]           req_command;
   logic signed [pidl_pkg::DATA_W-1:0]   req_value;
   logic [pidl_pkg::INDEX_W-1:0]         req_index;
   logic                                 req_start_req;
   logic                                 rsp_valid;
   logic [pidl_pkg::STATUS_W-1:0]        rsp_status;
   logic signed [pidl_pkg::DATA_W-1:0]   rsp_data;
   logic [pidl_pkg::COUNT_OUT_W-1:0]     rsp_count;

   // shadow copy of the list kept by the predictor
   logic signed [pidl_pkg::DATA_W-1:0]   shadow_elems [0:LIST_CAP-1];
   int                                   shadow_len;

   list_result_type                      pending_results [$];
   list_result_type                      typed_result;
   bit                                   typed_valid;
   list_result_type                      want;
   list_result_type                      predicted;
   opening_row_type                      opening_rows [0:ROW_COUNT-1];

   int                                   fail_count;
   int                                   cycle_count;
   int                                   sent_count;
   int                                   checked_count;
   int                                   full_count;
   int                                   range_count;
   int                                   peak_len;
   int                                   cmd_seen [0:3];

   positional_insert_delete_list i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_value     (req_value),
      .req_index     (req_index),
      .req_start_req (req_start_req),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_data      (rsp_data),
      .rsp_count     (rsp_count)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // applies one command to the shadow list and returns its response
   function automatic list_result_type list_apply(pidl_pkg::cmd_type c,
                                                  logic signed [pidl_pkg::DATA_W-1:0] v,
                                                  logic [pidl_pkg::INDEX_W-1:0] idx,
                                                  logic restart);
      list_result_type r;
      int              k;
      int              pos;
      r.status = pidl_pkg::STAT_OK;
      r.data   = '0;
      pos      = int'(idx);
      case (c)
         pidl_pkg::CMD_LOAD: begin
            if (restart) shadow_len = 0;
            if (shadow_len >= LIST_CAP) begin
               r.status = pidl_pkg::STAT_FULL;
            end else begin
               shadow_elems[shadow_len] = v;
               shadow_len++;
            end
         end
         pidl_pkg::CMD_READ: begin
            if (pos < shadow_len) r.data = shadow_elems[pos];
            else r.status = pidl_pkg::STAT_RANGE;
         end
         pidl_pkg::CMD_INSERT: begin
            // index check wins over the full check
            if (pos > shadow_len) begin
               r.status = pidl_pkg::STAT_RANGE;
            end else if (shadow_len >= LIST_CAP) begin
               r.status = pidl_pkg::STAT_FULL;
            end else begin
               for (k = shadow_len; k > pos; k--) shadow_elems[k] = shadow_elems[k-1];
               shadow_elems[pos] = v;
               shadow_len++;
            end
         end
         default: begin
            if (pos < shadow_len) begin
               r.data = shadow_elems[pos];
               for (k = pos; k + 1 < shadow_len; k++) shadow_elems[k] = shadow_elems[k+1];
               shadow_len--;
            end else begin
               r.status = pidl_pkg::STAT_RANGE;
            end
         end
      endcase
      r.count = pidl_pkg::COUNT_OUT_W'(shadow_len);
      return r;
   endfunction

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endfunction

   // mostly back to back, sometimes a short gap, now and then a long one; none when quiet
   function automatic int pick_gap(bit quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 65) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 25);
   endfunction

   function automatic logic signed [pidl_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   // check the response of the previous transaction, then predict the one
   // taken on this edge; the order keeps a single queue consistent
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (rsp_valid !== 1'b0) begin
            checked_count++;
            if (pending_results.size() == 0) begin
               note_failure($sformatf("response with none pending: status %0d data %0d count %0d",
                                      rsp_status, rsp_data, rsp_count));
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status || rsp_data !== want.data ||
                   rsp_count !== want.count)
                  note_failure($sformatf({"expected status %0d data %0d count %0d, ",
                                          "got status %0d data %0d count %0d"},
                                         want.status, want.data, want.count,
                                         rsp_status, rsp_data, rsp_count));
            end
         end
         if (start && busy === 1'b0) begin
            predicted = list_apply(pidl_pkg::cmd_type'(req_command), req_value, req_index,
                                   req_start_req);
            // typed-in rows replace the predicted response
            if (typed_valid) predicted = typed_result;
            pending_results.push_back(predicted);
            cmd_seen[req_command]++;
            if (predicted.status == pidl_pkg::STAT_FULL) full_count++;
            if (predicted.status == pidl_pkg::STAT_RANGE) range_count++;
            if (shadow_len > peak_len) peak_len = shadow_len;
         end
      end
   end

   // guard against a hang
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses pending",
                  cycle_count, pending_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // drive one transaction at the falling edge and hold it until taken
   task automatic issue_cmd(pidl_pkg::cmd_type c, logic signed [pidl_pkg::DATA_W-1:0] v,
                            logic [pidl_pkg::INDEX_W-1:0] idx, logic restart,
                            bit typed, list_result_type res);
      @(negedge clock);
      start         <= 1'b1;
      req_command   <= c;
      req_value     <= v;
      req_index     <= idx;
      req_start_req <= restart;
      typed_valid   = typed;
      typed_result  = res;
      do @(posedge clock); while (busy !== 1'b0);
      sent_count++;
   endtask

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   initial begin
      int                                 r;
      int                                 k;
      int                                 mode;
      int                                 ep_len;
      int                                 roll;
      int                                 top;
      bit                                 quiet;
      pidl_pkg::cmd_type                  c;
      logic [pidl_pkg::INDEX_W-1:0]       idx;
      logic                               restart;
      logic signed [pidl_pkg::DATA_W-1:0] v;
      list_result_type                    res;

      reset         = 1'b1;
      start         = 1'b0;
      req_command   = pidl_pkg::CMD_LOAD;
      req_value     = '0;
      req_index     = '0;
      req_start_req = 1'b0;
      typed_valid   = 1'b0;
      typed_result  = '{pidl_pkg::STAT_OK, '0, '0};
      shadow_len    = 0;
      fail_count    = 0;
      cycle_count   = 0;
      sent_count    = 0;
      checked_count = 0;
      full_count    = 0;
      range_count   = 0;
      peak_len      = 0;
      for (k = 0; k < 4; k++) cmd_seen[k] = 0;

      // cmd, value, index, start_req, reps, typed, then status, data, count
      opening_rows = '{
         // empty list: every indexed access is out of range
         '{pidl_pkg::CMD_READ,   32'h0,         6'd0,  1'b0, 1,  1'b1,
           pidl_pkg::STAT_RANGE, 32'h0,         7'd0},
         '{pidl_pkg::CMD_DELETE, 32'h0,         6'd63, 1'b0, 1,  1'b1,
           pidl_pkg::STAT_RANGE, 32'h0,         7'd0},
         '{pidl_pkg::CMD_INSERT, 32'h1,         6'd1,  1'b0, 1,  1'b1,
           pidl_pkg::STAT_RANGE, 32'h0,         7'd0},
         // insert at the count appends
         '{pidl_pkg::CMD_INSERT, 32'h7fff_ffff, 6'd0,  1'b0, 1,  1'b1,
           pidl_pkg::STAT_OK,    32'h0,         7'd1},
         '{pidl_pkg::CMD_LOAD,   32'h8000_0000, 6'd63, 1'b0, 1,  1'b1,
           pidl_pkg::STAT_OK,    32'h0,         7'd2},
         '{pidl_pkg::CMD_READ,   32'h0,         6'd0,  1'b0, 1,  1'b1,
           pidl_pkg::STAT_OK,    32'h7fff_ffff, 7'd2},
         '{pidl_pkg::CMD_READ,   32'h0,         6'd1,  1'b0, 1,  1'b1,
           pidl_pkg::STAT_OK,    32'h8000_0000, 7'd2},
         '{pidl_pkg::CMD_READ,   32'h0,         6'd2,  1'b0, 1,  1'b1,
           pidl_pkg::STAT_RANGE, 32'h0,         7'd2},
         '{pidl_pkg::CMD_INSERT, 32'hffff_ffff, 6'd2,  1'b0, 1,  1'b1,
           pidl_pkg::STAT_OK,    32'h0,         7'd3},
         // shifting cases, checked by the predictor
         '{pidl_pkg::CMD_INSERT, 32'h5555_aaaa, 6'd1,  1'b0, 1,  1'b0,
           pidl_pkg::STAT_OK,    32'h0,         7'd0},
         '{pidl_pkg::CMD_DELETE, 32'h0,         6'd0,  1'b0, 1,  1'b0,
           pidl_pkg::STAT_OK,    32'h0,         7'd0},
         '{pidl_pkg::CMD_READ,   32'h0,         6'd1,  1'b1, 1,  1'b0,
           pidl_pkg::STAT_OK,    32'h0,         7'd0},
         // restart on load empties first
         '{pidl_pkg::CMD_LOAD,   32'haaaa_5555, 6'd0,  1'b1, 1,  1'b1,
           pidl_pkg::STAT_OK,    32'h0,         7'd1},
         // fill to capacity, mostly with random values
         '{pidl_pkg::CMD_LOAD,   32'h0,         6'd0,  1'b0, 63, 1'b0,
           pidl_pkg::STAT_OK,    32'h0,         7'd0},
         // full list: load and valid inserts are refused
         '{pidl_pkg::CMD_LOAD,   32'h1,         6'd0,  1'b0, 1,  1'b1,
           pidl_pkg::STAT_FULL,  32'h0,         7'd64},
         '{pidl_pkg::CMD_INSERT, 32'h2,         6'd0,  1'b0, 1,  1'b1,
           pidl_pkg::STAT_FULL,  32'h0,         7'd64},
         '{pidl_pkg::CMD_INSERT, 32'h3,         6'd63, 1'b0, 1,  1'b1,
           pidl_pkg::STAT_FULL,  32'h0,         7'd64},
         '{pidl_pkg::CMD_READ,   32'h0,         6'd63, 1'b0, 1,  1'b0,
           pidl_pkg::STAT_OK,    32'h0,         7'd0},
         '{pidl_pkg::CMD_DELETE, 32'h0,         6'd63, 1'b0, 1,  1'b0,
           pidl_pkg::STAT_OK,    32'h0,         7'd0},
         '{pidl_pkg::CMD_DELETE, 32'h0,         6'd63, 1'b0, 1,  1'b1,
           pidl_pkg::STAT_RANGE, 32'h0,         7'd63},
         // append at the top slot brings it back to full
         '{pidl_pkg::CMD_INSERT, 32'h1234_5678, 6'd63, 1'b0, 1,  1'b1,
           pidl_pkg::STAT_OK,    32'h0,         7'd64},
         '{pidl_pkg::CMD_DELETE, 32'h0,         6'd0,  1'b0, 1,  1'b0,
           pidl_pkg::STAT_OK,    32'h0,         7'd0},
         '{pidl_pkg::CMD_READ,   32'h0,         6'd0,  1'b0, 1,  1'b0,
           pidl_pkg::STAT_OK,    32'h0,         7'd0},
         '{pidl_pkg::CMD_LOAD,   32'hffff_ffff, 6'd5,  1'b1, 1,  1'b1,
           pidl_pkg::STAT_OK,    32'h0,         7'd1},
         '{pidl_pkg::CMD_READ,   32'h0,         6'd0,  1'b0, 1,  1'b1,
           pidl_pkg::STAT_OK,    32'hffff_ffff, 7'd1}
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opening
      for (r = 0; r < ROW_COUNT; r++) begin
         for (k = 0; k < opening_rows[r].reps; k++) begin
            v   = (k == 0) ? opening_rows[r].value : $urandom;
            res = '{opening_rows[r].status, opening_rows[r].data, opening_rows[r].count};
            issue_cmd(opening_rows[r].cmd, v, opening_rows[r].index, opening_rows[r].start_req,
                      opening_rows[r].typed, res);
            idle_cycles(pick_gap(1'b0));
         end
      end

      // random episodes: grow toward full, shrink toward empty, or churn
      res = '{pidl_pkg::STAT_OK, '0, '0};
      while (sent_count < ROW_COUNT + 62 + RAND_ITEMS) begin
         mode   = $urandom_range(0, 2);
         ep_len = (mode == 0) ? $urandom_range(40, 140) : $urandom_range(15, 60);
         quiet  = ($urandom_range(0, 99) < 30);
         for (k = 0; k < ep_len && sent_count < ROW_COUNT + 62 + RAND_ITEMS; k++) begin
            roll = $urandom_range(0, 99);
            case (mode)
               0: c = (roll < 45) ? pidl_pkg::CMD_LOAD : (roll < 85) ? pidl_pkg::CMD_INSERT :
                      (roll < 95) ? pidl_pkg::CMD_READ : pidl_pkg::CMD_DELETE;
               1: c = (roll < 10) ? pidl_pkg::CMD_LOAD : (roll < 25) ? pidl_pkg::CMD_INSERT :
                      (roll < 45) ? pidl_pkg::CMD_READ : pidl_pkg::CMD_DELETE;
               default: c = pidl_pkg::cmd_type'(roll % 4);
            endcase
            // mostly legal indexes, the rest anywhere in the field
            top = (c == pidl_pkg::CMD_INSERT) ? shadow_len : shadow_len - 1;
            if (top > 63) top = 63;
            if (top >= 0 && $urandom_range(0, 99) < 85)
               idx = pidl_pkg::INDEX_W'($urandom_range(0, top));
            else
               idx = pidl_pkg::INDEX_W'($urandom_range(0, 63));
            if (c == pidl_pkg::CMD_LOAD)
               restart = ($urandom_range(0, 99) < ((mode == 0) ? 1 : 6));
            else
               restart = 1'($urandom_range(0, 1));
            issue_cmd(c, pick_value(), idx, restart, 1'b0, res);
            idle_cycles(pick_gap(quiet));
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // a short wait catches any stray response
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_results.size() != 0)
         note_failure($sformatf("%0d responses never arrived", pending_results.size()));

      $display("ran %0d load, %0d read, %0d insert, %0d delete transactions",
               cmd_seen[pidl_pkg::CMD_LOAD], cmd_seen[pidl_pkg::CMD_READ],
               cmd_seen[pidl_pkg::CMD_INSERT], cmd_seen[pidl_pkg::CMD_DELETE]);
      $display("%0d full, %0d out of range; list length peaked at %0d of %0d",
               full_count, range_count, peak_len, LIST_CAP);
      $display("%0d responses checked, %0d failures", checked_count, fail_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> positional_insert_delete_list.f
rtl/pidl_pkg.sv
rtl/pidl_cell.sv
rtl/positional_insert_delete_list.sv
verif/tb_positional_insert_delete_list.sv
